@@ src/vshc_pkg.sv @@
// shared constants, types and helpers for the validated sample history cache
`timescale 1ns / 1ps
`default_nettype none

package vshc_pkg;

  localparam int MaxEntries  = 16;
  localparam int PayloadBits = 64;
  localparam int IdxW        = $clog2(MaxEntries);
  localparam int CntW        = $clog2(MaxEntries + 1);
  localparam int CapW        = 5;
  localparam int DataW       = 64;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [CapW-1:0] cap_t;

  typedef enum logic [1:0] {
    CmdObserve = 2'd0,
    CmdFind    = 2'd1,
    CmdLatest  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StAdded         = 3'd0,
    StUnchanged     = 3'd1,
    StSeqRegression = 3'd2,
    StInvalid       = 3'd3,
    StSmpRegression = 3'd4,
    StHit           = 3'd5,
    StMiss          = 3'd6
  } status_e;

  typedef enum logic {
    FsmIdle,
    FsmExec
  } fsm_e;

  typedef struct packed {
    logic [DataW-1:0]       sequence_no;
    logic [PayloadBits-1:0] payload;
    logic [DataW-1:0]       sample_number;
    logic [DataW-1:0]       source_time;
    logic [DataW-1:0]       validated_time;
  } entry_t;

  // zero acts as one, anything above the ring depth acts as the depth
  function automatic logic [CntW-1:0] eff_capacity(input logic [CapW-1:0] cap);
    logic [CntW-1:0] res;
    if (cap == '0) begin
      res = CntW'(1);
    end else if (32'(cap) > MaxEntries) begin
      res = CntW'(MaxEntries);
    end else begin
      res = CntW'(cap);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/vshc_store.sv @@
// sample ring storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module vshc_store (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [vshc_pkg::IdxW-1:0]      wr_addr_i,
  input  wire vshc_pkg::entry_t               wr_data_i,
  input  wire logic [vshc_pkg::IdxW-1:0]      rd_addr_i,
  output      vshc_pkg::entry_t               rd_data_o
);

  vshc_pkg::entry_t ring_q [vshc_pkg::MaxEntries];
  vshc_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= ring_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/validated_sample_history_cache_top.sv @@
// top level: command handling, ring pointers and configuration register
`timescale 1ns / 1ps
`default_nettype none

// Validated sample history cache. A command is taken when start is high and busy is low;
// its single result appears on the result ports in the cycle after the command completes,
// with done_o high for exactly one cycle, and must be captured then, as the block cannot be
// held off. Busy stays high until the command completes, so no new command is taken while
// one is executing. Observe, latest and unknown commands complete in their single execute
// state. Find reads the ring newest first through the single read port of the storage, one
// entry per cycle, and stays busy until it finds a match or has examined every stored entry
// (at most 16). The capacity register lies at byte address 0; the user must write it only
// while the block is idle, as the block itself does not enforce this.

module validated_sample_history_cache_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [63:0] published_sequence_i,
  input  wire logic [63:0] payload_word_i,
  input  wire logic        sample_validated_i,
  input  wire logic [63:0] sample_number_i,
  input  wire logic [63:0] source_time_ns_i,
  input  wire logic [63:0] validated_time_ns_i,

  output      logic        done_o,
  output      logic [2:0]  status_o,
  output      logic [63:0] entry_sequence_o,
  output      logic [63:0] entry_payload_o,
  output      logic [63:0] entry_sample_number_o,
  output      logic [63:0] entry_source_time_ns_o,
  output      logic [63:0] entry_validated_time_ns_o,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  vshc_pkg::fsm_e    state_q, state_d;
  vshc_pkg::cmd_e    cmd_q;
  logic [63:0]       seq_q, payload_q, id_q, src_q, vt_q;
  logic              validated_q;
  logic [63:0]       last_seq_q, last_seq_d;
  vshc_pkg::idx_t    oldest_q, oldest_d;
  vshc_pkg::cnt_t    count_q, count_d;
  vshc_pkg::cap_t    cap_q;
  vshc_pkg::idx_t    scan_q, scan_d;
  logic              done_q;
  vshc_pkg::status_e status_q, status_d;
  vshc_pkg::entry_t  res_q, res_d;

  logic              accept;
  logic              finish;
  logic              cfg_we;
  vshc_pkg::cnt_t    cap_eff, cap_new;
  vshc_pkg::idx_t    newest_slot;
  vshc_pkg::idx_t    rd_addr;
  logic              mem_we;
  vshc_pkg::idx_t    wr_addr;
  vshc_pkg::entry_t  wr_entry;
  vshc_pkg::entry_t  rd_entry;

  assign busy    = (state_q != vshc_pkg::FsmIdle);
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && !paddr[2];
  assign prdata  = paddr[2] ? 32'd0 : 32'(cap_q);
  assign cap_eff = vshc_pkg::eff_capacity(cap_q);
  assign cap_new = vshc_pkg::eff_capacity(pwdata[vshc_pkg::CapW-1:0]);

  assign newest_slot = oldest_q + vshc_pkg::idx_t'(count_q - vshc_pkg::cnt_t'(1));
  assign wr_addr     = oldest_q + vshc_pkg::idx_t'(count_q);

  assign wr_entry.sequence_no    = seq_q;
  assign wr_entry.payload        = payload_q[vshc_pkg::PayloadBits-1:0];
  assign wr_entry.sample_number  = id_q;
  assign wr_entry.source_time    = src_q;
  assign wr_entry.validated_time = vt_q;

  vshc_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vshc_pkg::FsmIdle: begin
        if (accept) begin
          state_d = vshc_pkg::FsmExec;
        end
      end
      vshc_pkg::FsmExec: begin
        if (finish) begin
          state_d = vshc_pkg::FsmIdle;
        end
      end
      default: state_d = vshc_pkg::FsmIdle;
    endcase
  end

  // command execution; read data belongs to the address issued in the previous cycle
  always_comb begin
    finish     = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = newest_slot;
    status_d   = vshc_pkg::StMiss;
    res_d      = '0;
    last_seq_d = last_seq_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    scan_d     = scan_q;

    case (state_q)
      vshc_pkg::FsmIdle: begin
        scan_d = vshc_pkg::idx_t'(count_q - vshc_pkg::cnt_t'(1));
        // capacity lowered below fill level: drop the oldest entries at once
        if (cfg_we && (count_q > cap_new)) begin
          oldest_d = oldest_q + vshc_pkg::idx_t'(count_q - cap_new);
          count_d  = cap_new;
        end
      end
      vshc_pkg::FsmExec: begin
        case (cmd_q)
          vshc_pkg::CmdObserve: begin
            finish = 1'b1;
            if ((seq_q == '0) || seq_q[0]) begin
              status_d = vshc_pkg::StInvalid;
            end else if (seq_q == last_seq_q) begin
              status_d = vshc_pkg::StUnchanged;
            end else if (seq_q < last_seq_q) begin
              status_d = vshc_pkg::StSeqRegression;
            end else begin
              last_seq_d = seq_q;
              if (!validated_q || (id_q == '0) || (src_q == '0) || (vt_q < src_q)) begin
                status_d = vshc_pkg::StInvalid;
              end else if ((count_q != '0) && ((id_q <= rd_entry.sample_number) ||
                                              (src_q < rd_entry.source_time))) begin
                status_d = vshc_pkg::StSmpRegression;
              end else begin
                status_d = vshc_pkg::StAdded;
                mem_we   = 1'b1;
                if (count_q < cap_eff) begin
                  count_d = count_q + vshc_pkg::cnt_t'(1);
                end else begin
                  oldest_d = oldest_q + vshc_pkg::idx_t'(1);
                end
              end
            end
          end
          vshc_pkg::CmdFind: begin
            if (count_q == '0) begin
              finish = 1'b1;
            end else if ((rd_entry.sample_number == id_q) &&
                         (rd_entry.source_time == src_q)) begin
              finish   = 1'b1;
              status_d = vshc_pkg::StHit;
              res_d    = rd_entry;
            end else if (scan_q == '0) begin
              finish = 1'b1;
            end else begin
              scan_d  = scan_q - vshc_pkg::idx_t'(1);
              rd_addr = oldest_q + scan_q - vshc_pkg::idx_t'(1);
            end
          end
          vshc_pkg::CmdLatest: begin
            finish = 1'b1;
            if (count_q != '0) begin
              status_d = vshc_pkg::StHit;
              res_d    = rd_entry;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vshc_pkg::FsmIdle;
      cmd_q      <= vshc_pkg::CmdObserve;
      last_seq_q <= '0;
      oldest_q   <= '0;
      count_q    <= '0;
      cap_q      <= vshc_pkg::cap_t'(vshc_pkg::MaxEntries);
      scan_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_seq_q <= last_seq_d;
      oldest_q   <= oldest_d;
      count_q    <= count_d;
      scan_q     <= scan_d;
      done_q     <= finish;
      if (accept) begin
        cmd_q <= vshc_pkg::cmd_e'(cmd_i);
      end
      if (cfg_we) begin
        cap_q <= pwdata[vshc_pkg::CapW-1:0];
      end
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q       <= published_sequence_i;
      payload_q   <= payload_word_i;
      validated_q <= sample_validated_i;
      id_q        <= sample_number_i;
      src_q       <= source_time_ns_i;
      vt_q        <= validated_time_ns_i;
    end
    if (finish) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign done_o                   = done_q;
  assign status_o                 = status_q;
  assign entry_sequence_o         = res_q.sequence_no;
  assign entry_payload_o          = 64'(res_q.payload);
  assign entry_sample_number_o    = res_q.sample_number;
  assign entry_source_time_ns_o   = res_q.source_time;
  assign entry_validated_time_ns_o = res_q.validated_time;

endmodule

`default_nettype wire

@@ tb/sv/validated_sample_history_cache_top_test.sv @@
// self-checking testbench for the validated sample history cache top level
`timescale 1ns / 1ps

module validated_sample_history_cache_top_test;

  localparam logic [1:0] CmdUnknown   = 2'd3;
  localparam logic [2:0] CapAddr      = 3'd0;
  localparam int         SettleCycles = 20;
  localparam int         PhaseItems   = 180;
  localparam int         PhaseCount   = 10;
  localparam logic [63:0] AllOnes     = '1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] seq;
    logic [63:0] payload;
    logic        validated;
    logic [63:0] id;
    logic [63:0] src;
    logic [63:0] vt;
  } sample_cmd_t;

  typedef struct packed {
    vshc_pkg::status_e status;
    vshc_pkg::entry_t  entry;
  } history_result_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  logic [1:0]  cmd_i                = '0;
  logic [63:0] published_sequence_i = '0;
  logic [63:0] payload_word_i       = '0;
  logic        sample_validated_i   = 1'b0;
  logic [63:0] sample_number_i      = '0;
  logic [63:0] source_time_ns_i     = '0;
  logic [63:0] validated_time_ns_i  = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [63:0] entry_sequence_o;
  logic [63:0] entry_payload_o;
  logic [63:0] entry_sample_number_o;
  logic [63:0] entry_source_time_ns_o;
  logic [63:0] entry_validated_time_ns_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the cache state
  vshc_pkg::cap_t   model_capacity = vshc_pkg::cap_t'(16);
  logic [63:0]      model_last_seq = '0;
  vshc_pkg::entry_t history_ring [vshc_pkg::MaxEntries];
  vshc_pkg::idx_t   oldest_slot    = '0;
  vshc_pkg::cnt_t   entry_total    = '0;

  history_result_t expected_results [$];
  int fail_count      = 0;
  int sender_idle_pct = 18;

  validated_sample_history_cache_top dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .start                    (start),
    .busy                     (busy),
    .cmd_i                    (cmd_i),
    .published_sequence_i     (published_sequence_i),
    .payload_word_i           (payload_word_i),
    .sample_validated_i       (sample_validated_i),
    .sample_number_i          (sample_number_i),
    .source_time_ns_i         (source_time_ns_i),
    .validated_time_ns_i      (validated_time_ns_i),
    .done_o                   (done_o),
    .status_o                 (status_o),
    .entry_sequence_o         (entry_sequence_o),
    .entry_payload_o          (entry_payload_o),
    .entry_sample_number_o    (entry_sample_number_o),
    .entry_source_time_ns_o   (entry_source_time_ns_o),
    .entry_validated_time_ns_o(entry_validated_time_ns_o),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int usable_capacity();
    if (model_capacity == 0) return 1;
    if (int'(model_capacity) > vshc_pkg::MaxEntries) return vshc_pkg::MaxEntries;
    return int'(model_capacity);
  endfunction

  function automatic vshc_pkg::idx_t ring_slot(input int age);
    return vshc_pkg::idx_t'((int'(oldest_slot) + age) % vshc_pkg::MaxEntries);
  endfunction

  function automatic vshc_pkg::entry_t newest_entry();
    if (entry_total == 0) return '0;
    return history_ring[ring_slot(int'(entry_total) - 1)];
  endfunction

  function automatic vshc_pkg::status_e observe_sample(input sample_cmd_t c);
    vshc_pkg::entry_t fresh;
    if (c.seq == 0 || c.seq[0]) return vshc_pkg::StInvalid;
    if (c.seq == model_last_seq) return vshc_pkg::StUnchanged;
    if (c.seq < model_last_seq) return vshc_pkg::StSeqRegression;
    // a good sequence sticks even when the sample is refused
    model_last_seq = c.seq;
    if (!c.validated || c.id == 0 || c.src == 0 || c.vt < c.src) return vshc_pkg::StInvalid;
    if (entry_total != 0 && (c.id <= newest_entry().sample_number ||
                             c.src < newest_entry().source_time)) begin
      return vshc_pkg::StSmpRegression;
    end
    fresh.sequence_no    = c.seq;
    fresh.payload        = c.payload[vshc_pkg::PayloadBits-1:0];
    fresh.sample_number  = c.id;
    fresh.source_time    = c.src;
    fresh.validated_time = c.vt;
    history_ring[ring_slot(int'(entry_total))] = fresh;
    if (int'(entry_total) < usable_capacity()) entry_total++;
    else oldest_slot = ring_slot(1);
    return vshc_pkg::StAdded;
  endfunction

  function automatic history_result_t predict_history(input sample_cmd_t c);
    history_result_t r;
    vshc_pkg::idx_t  s;
    r = '0;
    r.status = vshc_pkg::StMiss;
    case (c.cmd)
      vshc_pkg::CmdObserve: r.status = observe_sample(c);
      vshc_pkg::CmdFind: begin
        for (int k = int'(entry_total) - 1; k >= 0; k--) begin
          s = ring_slot(k);
          if (history_ring[s].sample_number == c.id && history_ring[s].source_time == c.src) begin
            r.status = vshc_pkg::StHit;
            r.entry  = history_ring[s];
            break;
          end
        end
      end
      vshc_pkg::CmdLatest: begin
        if (entry_total != 0) begin
          r.status = vshc_pkg::StHit;
          r.entry  = newest_entry();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic sample_cmd_t random_fields();
    sample_cmd_t c;
    c.cmd       = vshc_pkg::CmdObserve;
    c.seq       = {$urandom(), $urandom()};
    c.payload   = {$urandom(), $urandom()};
    c.validated = 1'($urandom_range(1));
    c.id        = {$urandom(), $urandom()};
    c.src       = {$urandom(), $urandom()};
    c.vt        = {$urandom(), $urandom()};
    return c;
  endfunction

  function automatic sample_cmd_t observe_cmd(input logic [63:0] seq, input logic [63:0] payload,
                                              input logic validated, input logic [63:0] id,
                                              input logic [63:0] src, input logic [63:0] vt);
    sample_cmd_t c;
    c.cmd       = vshc_pkg::CmdObserve;
    c.seq       = seq;
    c.payload   = payload;
    c.validated = validated;
    c.id        = id;
    c.src       = src;
    c.vt        = vt;
    return c;
  endfunction

  function automatic sample_cmd_t lookup_cmd(input logic [1:0] cmd, input logic [63:0] id,
                                             input logic [63:0] src);
    sample_cmd_t c;
    c     = random_fields();
    c.cmd = cmd;
    c.id  = id;
    c.src = src;
    return c;
  endfunction

  // next sample that passes every check, random payload
  function automatic sample_cmd_t good_observe();
    sample_cmd_t      c;
    vshc_pkg::entry_t top;
    c           = random_fields();
    top         = newest_entry();
    c.cmd       = vshc_pkg::CmdObserve;
    c.seq       = model_last_seq + 64'(2 * $urandom_range(1, 4));
    c.validated = 1'b1;
    if (entry_total == 0) begin
      c.id  = 64'($urandom_range(1, 1000));
      c.src = 64'($urandom_range(1, 5000));
    end else begin
      c.id  = top.sample_number + 64'($urandom_range(1, 1000));
      c.src = top.source_time + 64'($urandom_range(0, 5000));
    end
    c.vt = c.src + 64'($urandom_range(0, 100));
    return c;
  endfunction

  function automatic sample_cmd_t next_random_item();
    sample_cmd_t      c;
    vshc_pkg::entry_t pick;
    int               roll;
    c    = random_fields();
    roll = $urandom_range(99);
    if (roll < 50) begin
      c = good_observe();
    end else if (roll < 67) begin
      c.cmd = vshc_pkg::CmdFind;
      if (entry_total != 0 && (roll < 62 || $urandom_range(1) == 1)) begin
        pick  = history_ring[ring_slot($urandom_range(int'(entry_total) - 1))];
        c.id  = pick.sample_number;
        // exact hit, or near miss: right id, wrong source time
        c.src = (roll < 62) ? pick.source_time : pick.source_time + 64'd1;
      end
    end else if (roll < 75) begin
      c.cmd = vshc_pkg::CmdLatest;
    end else if (roll < 78) begin
      c.cmd = CmdUnknown;
    end else if (roll < 84) begin
      c = good_observe();
      case ($urandom_range(3))
        0: c.seq = '0;
        1: c.seq[0] = 1'b1;
        2: c.seq = model_last_seq;
        default: c.seq = (model_last_seq > 64'd6) ?
                         model_last_seq - 64'(2 * $urandom_range(1, 3)) : 64'd0;
      endcase
    end else if (roll < 92) begin
      c = good_observe();
      case ($urandom_range(3))
        0: c.validated = 1'b0;
        1: c.id = '0;
        2: c.src = '0;
        default: c.vt = c.src - 64'd1;
      endcase
    end else if (roll < 97) begin
      c = good_observe();
      if (entry_total != 0) begin
        if ($urandom_range(1) == 1) c.id = newest_entry().sample_number - 64'($urandom_range(0, 2));
        else c.src = newest_entry().source_time - 64'd1;
      end
    end else begin
      // noise with an odd sequence so the history is left alone
      c.seq[0] = 1'b1;
    end
    return c;
  endfunction

  task automatic send_item(input sample_cmd_t c);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start                <= 1'b1;
    cmd_i                <= c.cmd;
    published_sequence_i <= c.seq;
    payload_word_i       <= c.payload;
    sample_validated_i   <= c.validated;
    sample_number_i      <= c.id;
    source_time_ns_i     <= c.src;
    validated_time_ns_i  <= c.vt;
    do @(posedge clk_i); while (busy);
    expected_results.insert(expected_results.size(), predict_history(c));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input vshc_pkg::cap_t cap);
    logic [31:0] word;
    word                        = $urandom();
    word[vshc_pkg::CapW-1:0]    = cap;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model_capacity = cap;
    // lowering the capacity drops the oldest entries straight away
    if (int'(entry_total) > usable_capacity()) begin
      oldest_slot = ring_slot(int'(entry_total) - usable_capacity());
      entry_total = vshc_pkg::cnt_t'(usable_capacity());
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(model_capacity)) begin
      report_mismatch($sformatf("capacity readback got %h expected %h", prdata,
                                32'(model_capacity)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    history_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("entry_sequence", entry_sequence_o, want.entry.sequence_no);
        check_field("entry_payload", entry_payload_o, 64'(want.entry.payload));
        check_field("entry_sample_number", entry_sample_number_o, want.entry.sample_number);
        check_field("entry_source_time_ns", entry_source_time_ns_o, want.entry.source_time);
        check_field("entry_validated_time_ns", entry_validated_time_ns_o,
                    want.entry.validated_time);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_ring();
    send_item(lookup_cmd(vshc_pkg::CmdLatest, 64'd1, 64'd1));
    send_item(lookup_cmd(vshc_pkg::CmdFind, 64'd1, 64'd1));
    send_item(lookup_cmd(CmdUnknown, 64'd1, 64'd1));
  endtask

  task automatic test_sequence_rules();
    send_item(observe_cmd(64'd0, 64'd5, 1'b1, 64'd10, 64'd100, 64'd100));
    send_item(observe_cmd(64'd3, 64'd5, 1'b1, 64'd10, 64'd100, 64'd100));
    send_item(observe_cmd(64'd2, 64'd0, 1'b1, 64'd10, 64'd100, 64'd100));
    send_item(observe_cmd(64'd2, 64'd7, 1'b1, 64'd11, 64'd100, 64'd100));
    // refused sample still moves the sequence on
    send_item(observe_cmd(64'd4, 64'd7, 1'b0, 64'd11, 64'd100, 64'd100));
    send_item(observe_cmd(64'd4, 64'd7, 1'b1, 64'd11, 64'd100, 64'd100));
    send_item(observe_cmd(64'd2, 64'd7, 1'b1, 64'd11, 64'd100, 64'd100));
  endtask

  task automatic test_sample_rules();
    send_item(observe_cmd(64'd6, 64'd1, 1'b1, 64'd0, 64'd200, 64'd200));
    send_item(observe_cmd(64'd8, 64'd1, 1'b1, 64'd11, 64'd0, 64'd200));
    send_item(observe_cmd(64'd10, 64'd1, 1'b1, 64'd11, 64'd200, 64'd199));
    send_item(observe_cmd(64'd12, 64'd1, 1'b1, 64'd10, 64'd200, 64'd200));
    send_item(observe_cmd(64'd14, 64'd1, 1'b1, 64'd11, 64'd99, 64'd200));
    send_item(observe_cmd(64'd16, AllOnes, 1'b1, 64'd11, 64'd100, 64'd100));
  endtask

  task automatic test_lookup();
    send_item(lookup_cmd(vshc_pkg::CmdFind, 64'd10, 64'd100));
    send_item(lookup_cmd(vshc_pkg::CmdFind, 64'd11, 64'd100));
    send_item(lookup_cmd(vshc_pkg::CmdFind, 64'd11, 64'd101));
    send_item(lookup_cmd(vshc_pkg::CmdLatest, 64'd0, 64'd0));
    send_item(lookup_cmd(CmdUnknown, 64'd10, 64'd100));
  endtask

  // capacity sweep with mixed random traffic and idling that changes by phase
  task automatic test_random_history();
    vshc_pkg::cap_t cap;
    for (int p = 0; p < PhaseCount; p++) begin
      sender_idle_pct = (p < 3) ? 18 : (p < 6) ? 48 : 0;
      case (p)
        1: cap = vshc_pkg::cap_t'(3);
        2: cap = vshc_pkg::cap_t'(1);
        3: cap = vshc_pkg::cap_t'(0);
        4: cap = vshc_pkg::cap_t'(31);
        5: cap = vshc_pkg::cap_t'(16);
        6: cap = vshc_pkg::cap_t'(20);
        7: cap = vshc_pkg::cap_t'(7);
        8: cap = vshc_pkg::cap_t'(2);
        default: cap = vshc_pkg::cap_t'(16);
      endcase
      if (p != 0) write_capacity(cap);
      repeat (PhaseItems) send_item(next_random_item());
    end
  endtask

  task automatic test_field_extremes();
    send_item(observe_cmd(AllOnes - 64'd1, AllOnes, 1'b1, AllOnes, AllOnes, AllOnes));
    send_item(lookup_cmd(vshc_pkg::CmdLatest, 64'd0, 64'd0));
    send_item(lookup_cmd(vshc_pkg::CmdFind, AllOnes, AllOnes));
    send_item(observe_cmd(AllOnes - 64'd1, 64'd0, 1'b1, AllOnes, AllOnes, AllOnes));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_ring();
    test_sequence_rules();
    test_sample_rules();
    test_lookup();
    test_random_history();
    test_field_extremes();
    drain_results();
    if (fail_count == 0) begin
      $display("validated_sample_history_cache_top verification clean");
    end else begin
      $display("validated_sample_history_cache_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("validated_sample_history_cache_top verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/vshc_pkg.sv
src/vshc_store.sv
src/validated_sample_history_cache_top.sv
tb/sv/validated_sample_history_cache_top_test.sv
